FILE: rtl/rsrh_pkg.sv
// ----------------------------------------------------------------------------
// rsrh_pkg: shared types and constants for the segment/rectangle hit test
// Fixed angle encoding, CORDIC arctangent table and pipeline payload types.
// ----------------------------------------------------------------------------
package rsrh_pkg;

	localparam int AngW = 16;
	localparam logic [AngW-1:0] ANG_FULL = 16'd46080;
	localparam logic [AngW-1:0] ANG_QUARTER = 16'd11520;
	localparam logic [AngW-1:0] ANG_HALF = 16'd23040;
	localparam logic [AngW-1:0] ANG_THREEQ = 16'd34560;

	localparam int CordicSteps = 16;
	localparam int CordicW = 34;
	localparam int ZW = 30;
	localparam logic signed [CordicW-1:0] CORDIC_X0 = 34'sd652032874;

	function automatic logic signed [ZW-1:0] atan_deg(input logic [3:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			4'd0: r = 30'sd47185920;
			4'd1: r = 30'sd27855475;
			4'd2: r = 30'sd14718068;
			4'd3: r = 30'sd7471121;
			4'd4: r = 30'sd3750058;
			4'd5: r = 30'sd1876857;
			4'd6: r = 30'sd938658;
			4'd7: r = 30'sd469357;
			4'd8: r = 30'sd234682;
			4'd9: r = 30'sd117342;
			4'd10: r = 30'sd58671;
			4'd11: r = 30'sd29335;
			4'd12: r = 30'sd14668;
			4'd13: r = 30'sd7334;
			4'd14: r = 30'sd3667;
			default: r = 30'sd1833;
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic signed [CordicW-1:0] x;
		logic signed [CordicW-1:0] y;
		logic signed [ZW-1:0] z;
		logic neg;
	} cordic_t;

	typedef struct packed {
		logic signed [15:0] l;
		logic signed [15:0] t;
		logic signed [16:0] r;
		logic signed [16:0] b;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic [14:0] len;
	} geom_t;

endpackage

FILE: rtl/rsrh_cordic_stage.sv
// ----------------------------------------------------------------------------
// rsrh_cordic_stage: one registered CORDIC rotation step
// Applies micro-rotation STEP and carries the geometry alongside.
// ----------------------------------------------------------------------------
module rsrh_cordic_stage import rsrh_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_vld,
	input  cordic_t in_c,
	input  geom_t   in_g,
	output logic    out_vld,
	output cordic_t out_c,
	output geom_t   out_g
);

	cordic_t nxt;
	logic signed [CordicW-1:0] xs, ys;

	always_comb begin
		xs = in_c.x >>> STEP;
		ys = in_c.y >>> STEP;
		nxt = in_c;
		if (!in_c.z[ZW-1]) begin
			nxt.x = in_c.x - ys;
			nxt.y = in_c.y + xs;
			nxt.z = in_c.z - atan_deg(4'(STEP));
		end else begin
			nxt.x = in_c.x + ys;
			nxt.y = in_c.y - xs;
			nxt.z = in_c.z + atan_deg(4'(STEP));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld <= 1'b0;
		else if (en) out_vld <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_c <= nxt;
			out_g <= in_g;
		end
	end

endmodule

FILE: rtl/rsrh_cross.sv
// ----------------------------------------------------------------------------
// rsrh_cross: edge crossing test, three register stages
// Differences, cross products, then the sign tests against the denominator.
// ----------------------------------------------------------------------------
module rsrh_cross #(
	parameter int NEAR_LIM = 1
) (
	input  logic clk,
	input  logic en,
	input  logic signed [18:0] p1x, p1y, p2x, p2y,
	input  logic signed [18:0] p3x, p3y, p4x, p4y,
	output logic hit
);

	logic signed [19:0] ax_s1, ay_s1, ex_s1, ey_s1, wx_s1, wy_s1;
	logic signed [40:0] d_s2, tn_s2, un_s2;
	logic [40:0] ad_s2;

	function automatic logic in_unit(input logic signed [40:0] n, input logic signed [40:0] d);
		if (d > 0) return n >= 0 && n <= d;
		return n <= 0 && n >= d;
	endfunction

	// near-parallel: |d| below the limit counts as no crossing
	assign ad_s2 = d_s2[40] ? 41'(-d_s2) : 41'(d_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= 20'(p2x) - 20'(p1x);
			ay_s1 <= 20'(p2y) - 20'(p1y);
			ex_s1 <= 20'(p4x) - 20'(p3x);
			ey_s1 <= 20'(p4y) - 20'(p3y);
			wx_s1 <= 20'(p3x) - 20'(p1x);
			wy_s1 <= 20'(p3y) - 20'(p1y);
			d_s2  <= 41'(ax_s1 * ey_s1) - 41'(ay_s1 * ex_s1);
			tn_s2 <= 41'(wx_s1 * ey_s1) - 41'(wy_s1 * ex_s1);
			un_s2 <= 41'(wx_s1 * ay_s1) - 41'(wy_s1 * ax_s1);
			hit   <= (ad_s2 >= 41'(NEAR_LIM)) && in_unit(tn_s2, d_s2)
				&& in_unit(un_s2, d_s2);
		end
	end

endmodule

FILE: rtl/rotated_segment_rect_hit.sv
// ----------------------------------------------------------------------------
// rotated_segment_rect_hit: rotated segment versus axis-aligned rectangle
//
//  channel | signals                                   | dir
//  request | in_valid in_ready rect_* seg_*            | in
//  result  | out_valid out_ready hit                   | out
//
// One request per cycle while the pipe advances; stages: 1 angle fold, 16 CORDIC
// steps, 2 end point, 3 crossing, 1 output. The whole pipe advances when the
// output stage is empty or being taken; a stall freezes every stage.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module rotated_segment_rect_hit import rsrh_pkg::*; #(
	parameter int COORD_FRAC_BITS = 4,
	parameter int TRIG_FRAC_BITS = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] rect_x,
	input  logic signed [15:0] rect_y,
	input  logic [14:0]        rect_w,
	input  logic [14:0]        rect_h,
	input  logic signed [15:0] seg_x,
	input  logic signed [15:0] seg_y,
	input  logic [14:0]        seg_len,
	input  logic [15:0]        seg_angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit
);

	localparam int Sh = 30 - TRIG_FRAC_BITS;
	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam int Stages = CordicSteps + 1;
	localparam int NearLim = ((1 << (2 * COORD_FRAC_BITS)) + 9999) / 10000;

	logic en;
	logic [Stages-1:0] vld;
	cordic_t c [Stages];
	geom_t g [Stages];

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// angle fold
	logic [AngW-1:0] a0;
	logic signed [17:0] af;
	logic neg0;
	always_comb begin
		a0 = (seg_angle >= ANG_FULL) ? seg_angle - ANG_FULL : seg_angle;
		neg0 = 1'b0;
		af = 18'(a0);
		if (a0 > ANG_QUARTER && a0 < ANG_THREEQ) begin
			af = 18'(a0) - 18'(ANG_HALF);
			neg0 = 1'b1;
		end else if (a0 >= ANG_THREEQ) begin
			af = 18'(a0) - 18'(ANG_FULL);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld[0] <= 1'b0;
		else if (en) vld[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c[0].x <= CORDIC_X0;
			c[0].y <= '0;
			c[0].z <= ZW'(af) <<< 13;
			c[0].neg <= neg0;
			g[0].l <= rect_x;
			g[0].t <= rect_y;
			g[0].r <= 17'(rect_x) + 17'($signed({1'b0, rect_w}));
			g[0].b <= 17'(rect_y) + 17'($signed({1'b0, rect_h}));
			g[0].sx <= seg_x;
			g[0].sy <= seg_y;
			g[0].len <= seg_len;
		end
	end

	for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
		rsrh_cordic_stage #(.STEP(i)) u_stage (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_vld(vld[i]), .in_c(c[i]), .in_g(g[i]),
			.out_vld(vld[i+1]), .out_c(c[i+1]), .out_g(g[i+1])
		);
	end

	// trig rounding and clamp
	function automatic logic signed [TW-1:0] to_trig(input logic signed [CordicW-1:0] v,
			input logic ng);
		logic signed [CordicW:0] vv, r;
		vv = ng ? -(CordicW+1)'(v) : (CordicW+1)'(v);
		r = (vv + ((CordicW+1)'(1) <<< (Sh - 1))) >>> Sh;
		if (r > ((CordicW+1)'(1) <<< TRIG_FRAC_BITS)) r = (CordicW+1)'(1) <<< TRIG_FRAC_BITS;
		if (r < -((CordicW+1)'(1) <<< TRIG_FRAC_BITS)) r = -((CordicW+1)'(1) <<< TRIG_FRAC_BITS);
		return TW'(r);
	endfunction

	logic e1_vld, e2_vld;
	logic signed [TW+16:0] pc_e1, ps_e1;
	geom_t g_e1, g_e2;
	logic signed [18:0] ex_e2, ey_e2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_vld <= 1'b0;
			e2_vld <= 1'b0;
		end else if (en) begin
			e1_vld <= vld[Stages-1];
			e2_vld <= e1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pc_e1 <= (TW+17)'($signed({1'b0, g[Stages-1].len})
				* to_trig(c[Stages-1].x, c[Stages-1].neg));
			ps_e1 <= (TW+17)'($signed({1'b0, g[Stages-1].len})
				* to_trig(c[Stages-1].y, c[Stages-1].neg));
			g_e1 <= g[Stages-1];
			ex_e2 <= 19'(g_e1.sx) + 19'((pc_e1 + ((TW+17)'(1) <<< (TRIG_FRAC_BITS - 1)))
				>>> TRIG_FRAC_BITS);
			ey_e2 <= 19'(g_e1.sy) + 19'((ps_e1 + ((TW+17)'(1) <<< (TRIG_FRAC_BITS - 1)))
				>>> TRIG_FRAC_BITS);
			g_e2 <= g_e1;
		end
	end

	// endpoint test and crossing lanes
	logic signed [18:0] l19, t19, r19, b19, sx19, sy19;
	logic in_now;
	assign l19 = 19'(g_e2.l);
	assign t19 = 19'(g_e2.t);
	assign r19 = 19'(g_e2.r);
	assign b19 = 19'(g_e2.b);
	assign sx19 = 19'(g_e2.sx);
	assign sy19 = 19'(g_e2.sy);
	assign in_now = (sx19 >= l19 && sx19 <= r19 && sy19 >= t19 && sy19 <= b19)
		|| (ex_e2 >= l19 && ex_e2 <= r19 && ey_e2 >= t19 && ey_e2 <= b19);

	logic [3:0] xh;
	logic signed [18:0] cx [5], cy [5];
	always_comb begin
		cx[0] = l19; cy[0] = t19;
		cx[1] = r19; cy[1] = t19;
		cx[2] = r19; cy[2] = b19;
		cx[3] = l19; cy[3] = b19;
		cx[4] = l19; cy[4] = t19;
	end

	for (genvar k = 0; k < 4; k++) begin : g_edge
		rsrh_cross #(.NEAR_LIM(NearLim)) u_cross (
			.clk(clk), .en(en),
			.p1x(sx19), .p1y(sy19), .p2x(ex_e2), .p2y(ey_e2),
			.p3x(cx[k]), .p3y(cy[k]), .p4x(cx[k+1]), .p4y(cy[k+1]),
			.hit(xh[k])
		);
	end

	logic [2:0] xv;
	logic [2:0] in_d;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xv <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			xv <= {xv[1:0], e2_vld};
			out_valid <= xv[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_d <= {in_d[1:0], in_now};
			hit <= in_d[2] || (|xh);
		end
	end

endmodule

FILE: rtl/rsrh_checker.sv
// ----------------------------------------------------------------------------
// rsrh_checker: port-level checks for rotated_segment_rect_hit
// Handshake stability, ready behaviour and no result right after reset.
// ----------------------------------------------------------------------------
module rsrh_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic hit
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("request withdrawn while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit))
		else $error("result dropped or changed while stalled");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result right after reset");

endmodule

bind rotated_segment_rect_hit rsrh_checker u_rsrh_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .hit(hit)
);

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: segment/rectangle hit test bench
// Drives random and directed requests with bursty valid and a stalling
// receiver, predicts the hit bit with an independent CORDIC and crossing
// calculation, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CFB = 4;
	localparam int TFB = 15;
	localparam int LATENCY = 23;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic signed [15:0] rx;
		logic signed [15:0] ry;
		logic [14:0] rw;
		logic [14:0] rh;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic [14:0] len;
		logic [15:0] ang;
	} query_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, hit;
	query_t cur;

	query_t pending_q[$];
	logic hit_expected_q[$];
	int fail_cnt;
	int idle_cnt;
	bit stim_done;
	int gap_left, burst_left, stall_phase;
	bit drain_req;
	bit in_taken;

	rotated_segment_rect_hit #(.COORD_FRAC_BITS(CFB), .TRIG_FRAC_BITS(TFB)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.rect_x(cur.rx), .rect_y(cur.ry), .rect_w(cur.rw), .rect_h(cur.rh),
		.seg_x(cur.sx), .seg_y(cur.sy), .seg_len(cur.len), .seg_angle(cur.ang),
		.out_valid(out_valid), .out_ready(out_ready), .hit(hit)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint floor_shr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint trig_round(longint v);
		longint r, lim;
		lim = longint'(1) << TFB;
		r = floor_shr(v + (longint'(1) << (30 - TFB - 1)), 30 - TFB);
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	function automatic void rotate_unit(logic [15:0] ang, output longint c, output longint s);
		longint a, x, y, z, xs, ys;
		longint atab[16];
		bit flip;
		atab = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
			469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833};
		a = ang;
		x = 652032874;
		y = 0;
		flip = 0;
		if (a >= 46080) a -= 46080;
		if (a > 11520 && a < 34560) begin
			a -= 23040;
			flip = 1;
		end else if (a >= 34560) begin
			a -= 46080;
		end
		z = a * 8192;
		for (int i = 0; i < 16; i++) begin
			xs = floor_shr(x, i);
			ys = floor_shr(y, i);
			if (z >= 0) begin
				x -= ys; y += xs; z -= atab[i];
			end else begin
				x += ys; y -= xs; z += atab[i];
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = trig_round(x);
		s = trig_round(y);
	endfunction

	function automatic bit within_span(longint n, longint d);
		if (d > 0) return n >= 0 && n <= d;
		return n <= 0 && n >= d;
	endfunction

	function automatic bit edge_crossed(longint p1x, longint p1y, longint p2x, longint p2y,
			longint p3x, longint p3y, longint p4x, longint p4y);
		longint ax, ay, ex, ey, wx, wy, d, ad;
		ax = p2x - p1x; ay = p2y - p1y;
		ex = p4x - p3x; ey = p4y - p3y;
		wx = p3x - p1x; wy = p3y - p1y;
		d = ax * ey - ay * ex;
		ad = d < 0 ? -d : d;
		if (ad * 10000 < (longint'(1) << (2 * CFB))) return 0;
		return within_span(wx * ey - wy * ex, d) && within_span(wx * ay - wy * ax, d);
	endfunction

	function automatic bit predict_hit(query_t q);
		longint l, t, r, b, sx, sy, len, c, s, ex, ey;
		longint cx[4], cy[4];
		bit h;
		l = q.rx; t = q.ry;
		r = l + longint'(q.rw);
		b = t + longint'(q.rh);
		sx = q.sx; sy = q.sy;
		len = q.len;
		rotate_unit(q.ang, c, s);
		ex = sx + floor_shr(len * c + (longint'(1) << (TFB - 1)), TFB);
		ey = sy + floor_shr(len * s + (longint'(1) << (TFB - 1)), TFB);
		if ((sx >= l && sx <= r && sy >= t && sy <= b) ||
				(ex >= l && ex <= r && ey >= t && ey <= b))
			return 1;
		cx = '{l, r, r, l};
		cy = '{t, t, b, b};
		h = 0;
		for (int i = 0; i < 4; i++)
			if (!h) h = edge_crossed(sx, sy, ex, ey, cx[i], cy[i], cx[(i + 1) % 4], cy[(i + 1) % 4]);
		return h;
	endfunction

	function automatic query_t rand_query(bit near);
		query_t q;
		q = query_t'($bits(query_t)'({$urandom, $urandom, $urandom, $urandom}));
		if (near) begin
			q.rx = $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
			q.ry = $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
			q.rw = 15'($urandom_range(0, 1500));
			q.rh = 15'($urandom_range(0, 1500));
			q.sx = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
			q.sy = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
			q.len = 15'($urandom_range(0, 4000));
			q.ang = 16'($urandom_range(0, 46079));
		end
		return q;
	endfunction

	function automatic query_t mk(int rx, int ry, int rw, int rh, int sx, int sy,
			int len, int ang);
		query_t q;
		q.rx = 16'(rx); q.ry = 16'(ry); q.rw = 15'(rw); q.rh = 15'(rh);
		q.sx = 16'(sx); q.sy = 16'(sy); q.len = 15'(len); q.ang = 16'(ang);
		return q;
	endfunction

	// driver: bursts and gaps, one pause until drained
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (drain_req && hit_expected_q.size() != 0) begin
					in_valid <= 1'b0;
				end else if (pending_q.size() != 0) begin
					drain_req = 0;
					cur <= pending_q.pop_front();
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
			stall_phase++;
			if (stall_phase % 300 < 120) out_ready <= 1'b1;
			else out_ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 7 != 0);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken = in_valid && in_ready;
			if (in_valid && in_ready) hit_expected_q.push_back(predict_hit(cur));
			if (out_valid && out_ready) begin
				if (hit_expected_q.size() == 0) begin
					$error("hit: result with nothing expected, actual %0b", hit);
					fail_cnt++;
				end else begin
					logic e;
					e = hit_expected_q.pop_front();
					if (hit !== e) begin
						$error("hit: expected %0b actual %0b", e, hit);
						fail_cnt++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt = 0;
			else idle_cnt++;
			if (idle_cnt >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		query_t q;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		cur = '0;
		fail_cnt = 0;
		idle_cnt = 0;
		gap_left = 0;
		burst_left = 0;
		stall_phase = 0;
		drain_req = 0;
		in_taken = 0;
		// directed: extremes, zero size, zero length, wrapped angles, axis angles
		pending_q.push_back(mk(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 0));
		pending_q.push_back(mk(32767, 32767, 32767, 32767, -32768, -32768, 32767, 5760));
		pending_q.push_back(mk(0, 0, 0, 0, -16, 0, 32, 0));
		pending_q.push_back(mk(0, 0, 0, 160, -16, 16, 32, 0));
		pending_q.push_back(mk(0, 0, 160, 0, 16, -16, 32, 11520));
		pending_q.push_back(mk(0, 0, 160, 160, 80, 80, 0, 0));
		pending_q.push_back(mk(0, 0, 160, 160, 200, 80, 0, 0));
		pending_q.push_back(mk(0, 0, 160, 160, -40, 80, 400, 0));
		pending_q.push_back(mk(0, 0, 160, 160, 80, -40, 400, 11520));
		pending_q.push_back(mk(0, 0, 160, 160, 200, 80, 400, 23040));
		pending_q.push_back(mk(0, 0, 160, 160, 80, 200, 400, 34560));
		pending_q.push_back(mk(0, 0, 160, 160, -40, -40, 400, 5760));
		pending_q.push_back(mk(0, 0, 160, 160, 200, 80, 400, 46080));
		pending_q.push_back(mk(0, 0, 160, 160, 200, 80, 400, 65535));
		pending_q.push_back(mk(0, 0, 160, 160, 80, 200, 400, 46080 + 34560));
		pending_q.push_back(mk(0, 0, 160, 160, 160, -40, 400, 11520));
		pending_q.push_back(mk(0, 0, 160, 160, -40, 160, 400, 0));
		pending_q.push_back(mk(0, 0, 160, 160, -40, -41, 400, 0));
		pending_q.push_back(mk(0, 0, 32767, 32767, -32768, -32768, 32767, 46079));
		pending_q.push_back(mk(-1, -1, 1, 1, 0, 0, 0, 0));
		#16 arst_n = 1'b1;
		for (int i = 0; i < 750; i++) begin
			q = rand_query($urandom_range(0, 3) != 0);
			pending_q.push_back(q);
			if (i == 300) begin
				wait (pending_q.size() == 0);
				drain_req = 1;
			end
		end
		wait (pending_q.size() == 0 && !in_valid);
		wait (hit_expected_q.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
